FILE: rtl/core/lrta_pkg.sv
// lrta_pkg: shared types, constants and the arctangent table for the
// lidar ring and time assignment block. No dependencies.
`default_nettype none

package lrta_pkg;

    localparam int INDEX_BITS_DEF    = 20;
    localparam int CORDIC_STAGES_DEF = 16;

    // pipeline depths of the fixed parts
    localparam int PRE_STAGES  = 2;   // square, sum
    localparam int SQRT_STAGES = 32;  // one result bit per stage
    localparam int RING_STAGES = 3;

    localparam int ATAN_LEN = 24;
    localparam int ATAN_W   = 23;
    localparam int ANG_W    = 26;     // signed degrees, Q.16
    localparam int CW       = 36;     // CORDIC vector width
    localparam int TIME_W   = 35;
    localparam int TLAS_W   = 22;

    typedef enum logic [1:0] {
        MODE_4  = 2'd0,
        MODE_16 = 2'd1,
        MODE_32 = 2'd2,
        MODE_64 = 2'd3
    } line_mode_t;

    // register indexes on the APB port (paddr[3:2])
    localparam logic [1:0] REG_LINE_MODE   = 2'd0;
    localparam logic [1:0] REG_COLUMN_TIME = 2'd1;
    localparam logic [1:0] REG_LASER_TIME  = 2'd2;

    // atan(2^-i) in degrees, Q.16, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
    };

    // side-band payload that rides alongside the arithmetic pipeline
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        strength;
        logic [TIME_W-1:0]  tcol;
        logic [TLAS_W-1:0]  tlas;
        logic               zero;
    } pay_t;

    typedef struct packed {
        logic       valid;
        logic       keep;
        logic [5:0] ring;
    } ring_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/lrta_hyp.sv
// lrta_hyp: pipelined horizontal range floor(sqrt(x^2 + y^2)).
// Depends on lrta_pkg.
`default_nettype none

module lrta_hyp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    output logic                    out_valid,
    output logic [31:0]             root
);

    localparam int NS = lrta_pkg::SQRT_STAGES;

    logic [31:0] ax, ay;
    logic [63:0] sqx_reg, sqy_reg, sum_reg;
    logic        v0_reg, v1_reg;

    logic [63:0] rem_reg [NS];
    logic [63:0] res_reg [NS];
    logic        vld_reg [NS];

    assign ax = x[31] ? 32'(-x) : 32'(x);
    assign ay = y[31] ? 32'(-y) : 32'(y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= 64'(ax) * 64'(ax);
        sqy_reg <= 64'(ay) * 64'(ay);
        sum_reg <= sqx_reg + sqy_reg;
    end

    // restoring root, test bit 1 << (62 - 2j) in stage j
    for (genvar j = 0; j < NS; j++)
    begin : g_sq
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] rem_in, res_in, rem_next, res_next;
        logic [64:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in = sum_reg;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        always_comb
        begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, rem_in} >= trial)
            begin
                rem_next = rem_in - trial[63:0];
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            res_reg[j] <= res_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (j == 0)
                vld_reg[j] <= v1_reg;
            else
                vld_reg[j] <= vld_reg[(j == 0) ? 0 : j-1];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign root      = res_reg[NS-1][31:0];

endmodule

`default_nettype wire

FILE: rtl/core/lrta_cordic.sv
// lrta_cordic: pipelined vectoring CORDIC, elevation angle of (r, z) in
// degrees Q.16. Depends on lrta_pkg.
`default_nettype none

module lrta_cordic #(
    parameter int STAGES = lrta_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic [31:0]                      r,
    input  wire logic signed [31:0]               z,
    output logic                                  out_valid,
    output logic signed [lrta_pkg::ANG_W-1:0]     ang
);

    localparam int CW = lrta_pkg::CW;
    localparam int AW = lrta_pkg::ANG_W;

    logic signed [CW-1:0] cx_reg  [STAGES];
    logic signed [CW-1:0] cy_reg  [STAGES];
    logic signed [AW-1:0] ang_reg [STAGES];
    logic                 vld_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_st
        localparam logic signed [AW-1:0] STEP =
            AW'(lrta_pkg::ATAN_TAB[i]);
        logic signed [CW-1:0] cx_in, cy_in, dx, dy;
        logic signed [AW-1:0] a_in;
        logic                 v_in;

        if (i == 0)
        begin : g_first
            assign cx_in = CW'({1'b0, r});
            assign cy_in = {{(CW-32){z[31]}}, z};
            assign a_in  = '0;
            assign v_in  = in_valid;
        end
        else
        begin : g_rest
            assign cx_in = cx_reg[i-1];
            assign cy_in = cy_reg[i-1];
            assign a_in  = ang_reg[i-1];
            assign v_in  = vld_reg[i-1];
        end

        // arithmetic shift rounds toward minus infinity
        assign dx = cy_in >>> i;
        assign dy = cx_in >>> i;

        always_ff @(posedge clk)
        begin
            if (!cy_in[CW-1])
            begin
                cx_reg[i]  <= cx_in + dx;
                cy_reg[i]  <= cy_in - dy;
                ang_reg[i] <= a_in + STEP;
            end
            else
            begin
                cx_reg[i]  <= cx_in - dx;
                cy_reg[i]  <= cy_in + dy;
                ang_reg[i] <= a_in - STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= v_in;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign ang       = ang_reg[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/lrta_ring.sv
// lrta_ring: three-stage map from elevation angle to ring number with the
// 16/32/64-line rules and the drop decision. Depends on lrta_pkg.
`default_nettype none

module lrta_ring (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic signed [lrta_pkg::ANG_W-1:0]  ang,
    input  wire lrta_pkg::line_mode_t               mode,
    output lrta_pkg::ring_res_t                     res
);

    localparam logic [29:0] DIV64 = 30'd6553600;   // 100 degrees in Q.16
    localparam logic [17:0] RECIP = 18'd167772;    // floor(2^40 / DIV64)

    function automatic logic signed [39:0] tdiv(input logic signed [39:0] n,
                                                input int unsigned k);
        logic [39:0] mag, q;
        mag = n[39] ? 40'(-n) : 40'(n);
        q   = mag >> k;
        return n[39] ? -$signed(q) : $signed(q);
    endfunction

    // stage 1
    logic signed [39:0] a40, n1, n2, n3, h100, nb, t1, t2, t3;
    logic signed [11:0] id1_reg, id2_reg, id3a_reg, id1b_reg, id2b_reg, id3ab_reg;
    logic [27:0]        nb_reg, nb2_reg;
    logic               br_reg, out_reg, br2_reg, out2_reg;
    logic               v1_reg, v2_reg;
    logic [45:0]        prod_reg;

    always_comb
    begin
        a40  = 40'(ang);
        n1   = a40 + 40'sd1048576;
        n2   = 40'sd3 * a40 + 40'sd6029312;
        n3   = 40'sd425984 - 40'sd3 * a40;
        h100 = 40'sd100 * a40;
        nb   = -40'sd112459776 - 40'sd200 * a40;
        t1   = tdiv(n1, 17);
        t2   = tdiv(n2, 18);
        t3   = tdiv(n3, 16);
    end

    always_ff @(posedge clk)
    begin
        id1_reg  <= t1[11:0];
        id2_reg  <= t2[11:0];
        id3a_reg <= t3[11:0];
        nb_reg   <= nb[27:0];
        br_reg   <= h100 < -40'sd57868288;
        out_reg  <= (a40 > 40'sd131072) || (h100 < -40'sd159449088);
        // stage 2: reciprocal product for the lower 64-line branch
        prod_reg  <= 46'(nb_reg) * 46'(RECIP);
        nb2_reg   <= nb_reg;
        id1b_reg  <= id1_reg;
        id2b_reg  <= id2_reg;
        id3ab_reg <= id3a_reg;
        br2_reg   <= br_reg;
        out2_reg  <= out_reg;
    end

    // stage 3: quotient correction, select and range check
    logic [5:0]         q0;
    logic [29:0]        rem;
    logic [5:0]         q;
    logic signed [11:0] id3, id;
    logic               keep;
    logic               keep_reg;
    logic               valid_reg;
    logic [5:0]         ring_reg;

    always_comb
    begin
        q0  = prod_reg[45:40];
        rem = {2'b0, nb2_reg} - 30'(q0 * DIV64);
        q   = q0 + 6'((rem >= DIV64) ? 1 : 0);
        id3 = br2_reg ? 12'(7'd32 + 7'(q)) : id3ab_reg;
        unique case (mode)
            lrta_pkg::MODE_4:
            begin
                id   = '0;
                keep = 1'b1;
            end
            lrta_pkg::MODE_16:
            begin
                id   = id1b_reg;
                keep = (id1b_reg >= 0) && (id1b_reg <= 12'sd15);
            end
            lrta_pkg::MODE_32:
            begin
                id   = id2b_reg;
                keep = (id2b_reg >= 0) && (id2b_reg <= 12'sd31);
            end
            lrta_pkg::MODE_64:
            begin
                id   = id3;
                keep = !out2_reg && (id3 >= 0) && (id3 <= 12'sd50);
            end
            default:
            begin
                id   = '0;
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        keep_reg <= keep;
        ring_reg <= id[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            valid_reg <= v2_reg;
        end
    end

    assign res = '{valid: valid_reg, keep: keep_reg, ring: ring_reg};

endmodule

`default_nettype wire

FILE: rtl/core/lidar_ring_and_time_assign.sv
// lidar_ring_and_time_assign: top level, APB register file, point side-band
// line and output register. Depends on lrta_pkg, lrta_hyp, lrta_cordic, lrta_ring.
//
// Usage:
//  - A point transfer is taken on a rising edge with start high and busy low.
//    busy stays low: the datapath is a fixed pipeline with no stall, so one
//    point can enter every cycle.
//  - The pipeline runs through the squares and their sum, 32 root stages
//    (one bit each), one CORDIC stage per rotation, three ring-mapping
//    stages and the output register. Throughput is one point per cycle.
//  - A kept point shows up on the result ports for exactly one cycle with
//    done high. A dropped point (ring out of range) gives no done pulse; the
//    order of kept points is preserved. The receiver cannot stall.
//  - Registers on APB (pready always high): 0x0 line_mode, 0x4 column_time,
//    0x8 laser_time. Write them only while no point is in flight.
//  - Reset (rst_n low, async) clears all valid bits and sets line_mode to
//    16 lines, both times to 0. Nothing in flight survives reset.
`default_nettype none

module lidar_ring_and_time_assign #(
    parameter int INDEX_BITS    = lrta_pkg::INDEX_BITS_DEF,
    parameter int CORDIC_STAGES = lrta_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // point channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [31:0]    pos_x,
    input  wire logic signed [31:0]    pos_y,
    input  wire logic signed [31:0]    pos_z,
    input  wire logic [15:0]           strength,
    input  wire logic [INDEX_BITS-1:0] point_index,
    // result channel
    output logic                       done,
    output logic signed [31:0]         out_x,
    output logic signed [31:0]         out_y,
    output logic signed [31:0]         out_z,
    output logic [15:0]                out_strength,
    output logic [5:0]                 ring,
    output logic [34:0]                point_time,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int HYP_LAT  = lrta_pkg::PRE_STAGES + lrta_pkg::SQRT_STAGES;
    localparam int ANG_LAT  = HYP_LAT + CORDIC_STAGES;
    localparam int LAT      = ANG_LAT + lrta_pkg::RING_STAGES;
    localparam int PC_W     = 16 + INDEX_BITS;
    localparam int TIME_W   = lrta_pkg::TIME_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    lrta_pkg::line_mode_t line_mode_reg;
    logic [15:0]          column_time_reg;
    logic [15:0]          laser_time_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg   <= lrta_pkg::MODE_16;
            column_time_reg <= '0;
            laser_time_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                lrta_pkg::REG_LINE_MODE:
                    line_mode_reg <= lrta_pkg::line_mode_t'(pwdata[1:0]);
                lrta_pkg::REG_COLUMN_TIME:
                    column_time_reg <= pwdata[15:0];
                lrta_pkg::REG_LASER_TIME:
                    laser_time_reg <= pwdata[15:0];
                default:
                    ; // unmapped: write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            lrta_pkg::REG_LINE_MODE:   prdata = {30'b0, line_mode_reg};
            lrta_pkg::REG_COLUMN_TIME: prdata = {16'b0, column_time_reg};
            lrta_pkg::REG_LASER_TIME:  prdata = {16'b0, laser_time_reg};
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Point intake: time products are formed here, the sum is taken at
    // the output register. idx split is by the lines-per-column of mode.
    // ---------------------------------------------------------------
    logic               accept;
    logic [2:0]         lg;
    logic [INDEX_BITS-1:0] hi_idx;
    logic [5:0]         lo_idx;
    logic [PC_W-1:0]    pc;
    lrta_pkg::pay_t     pay_in;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        unique case (line_mode_reg)
            lrta_pkg::MODE_4:  lg = 3'd2;
            lrta_pkg::MODE_16: lg = 3'd4;
            lrta_pkg::MODE_32: lg = 3'd5;
            lrta_pkg::MODE_64: lg = 3'd6;
            default:           lg = 3'd4;
        endcase
        hi_idx = point_index >> lg;
        lo_idx = point_index[5:0] & 6'((7'd1 << lg) - 7'd1);
        pc     = PC_W'(column_time_reg) * PC_W'(hi_idx);

        pay_in.x        = pos_x;
        pay_in.y        = pos_y;
        pay_in.z        = pos_z;
        pay_in.strength = strength;
        pay_in.tcol     = TIME_W'(pc);
        pay_in.tlas     = lrta_pkg::TLAS_W'(laser_time_reg * 22'(lo_idx));
        pay_in.zero     = (pos_x == 0) && (pos_y == 0) && (pos_z == 0);
    end

    // side-band line, one entry per pipeline stage; tap k lines up with
    // the arithmetic stage that registered on the same edge
    lrta_pkg::pay_t pl_reg [LAT];

    always_ff @(posedge clk)
    begin
        pl_reg[0] <= pay_in;
        for (int k = 1; k < LAT; k++)
        begin
            pl_reg[k] <= pl_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Arithmetic pipeline
    // ---------------------------------------------------------------
    logic                                hyp_valid;
    logic [31:0]                         hyp_root;
    logic                                cor_valid;
    logic signed [lrta_pkg::ANG_W-1:0]   cor_ang;
    logic signed [lrta_pkg::ANG_W-1:0]   ring_ang;
    lrta_pkg::ring_res_t                 rres;

    lrta_hyp u_hyp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .x         (pos_x),
        .y         (pos_y),
        .out_valid (hyp_valid),
        .root      (hyp_root)
    );

    lrta_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hyp_valid),
        .r         (hyp_root),
        .z         (pl_reg[HYP_LAT-1].z),
        .out_valid (cor_valid),
        .ang       (cor_ang)
    );

    // origin point: angle forced to 0
    assign ring_ang = pl_reg[ANG_LAT-1].zero ? '0 : cor_ang;

    lrta_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cor_valid),
        .ang      (ring_ang),
        .mode     (line_mode_reg),
        .res      (rres)
    );

    // ---------------------------------------------------------------
    // Output register: one-cycle done pulse per kept point
    // ---------------------------------------------------------------
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rres.valid && rres.keep;
    end

    always_ff @(posedge clk)
    begin
        out_x        <= pl_reg[LAT-1].x;
        out_y        <= pl_reg[LAT-1].y;
        out_z        <= pl_reg[LAT-1].z;
        out_strength <= pl_reg[LAT-1].strength;
        ring         <= rres.ring;
        point_time   <= pl_reg[LAT-1].tcol + TIME_W'(pl_reg[LAT-1].tlas);
    end

    assign done = done_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_hyp_align: assert property (@(posedge clk) disable iff (!rst_n)
        hyp_valid |-> $past(accept, HYP_LAT))
        else $error("root stage valid without matching transfer");

    a_ring_align: assert property (@(posedge clk) disable iff (!rst_n)
        rres.valid |-> $past(accept, LAT))
        else $error("ring stage valid out of step with side-band line");

    a_done_align: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT + 1))
        else $error("result strobe without matching transfer");

endmodule

`default_nettype wire
